### rtl/led_color_effect_generator_top_defines.svh
// Assertion macros for the LED colour effect generator
`ifndef LED_COLOR_EFFECT_GENERATOR_TOP_DEFINES_SVH
`define LED_COLOR_EFFECT_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LCE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define LCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define LCE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/lce_pkg.sv
// Types, codes and constants shared by the LED colour effect generator
`timescale 1ns / 1ps
package lce_pkg;

    localparam int PERIOD_W    = 20;
    localparam int PERIOD5_W   = 23;
    localparam int TIME_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [PERIOD_W-1:0]  STEP_PERIOD_RESET = 20'd100;
    localparam logic [PERIOD5_W-1:0] PERIOD_X5_RESET   = 23'd500;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_RED    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_GREEN  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_BLUE   = 2'd3;

    // effect kinds
    localparam logic [2:0] KIND_RAINBOW    = 3'd1;
    localparam logic [2:0] KIND_BREATHE    = 3'd2;
    localparam logic [2:0] KIND_SLOW_BLINK = 3'd3;
    localparam logic [2:0] KIND_BLINK      = 3'd4;

    // rainbow phases
    localparam logic [2:0] PHASE_RED_UP     = 3'd0;
    localparam logic [2:0] PHASE_GREEN_UP   = 3'd1;
    localparam logic [2:0] PHASE_RED_DOWN   = 3'd2;
    localparam logic [2:0] PHASE_BLUE_UP    = 3'd3;
    localparam logic [2:0] PHASE_GREEN_DOWN = 3'd4;
    localparam logic [2:0] PHASE_RED_UP2    = 3'd5;
    localparam logic [2:0] PHASE_BLUE_DOWN  = 3'd6;
    localparam logic [2:0] PHASE_UNUSED     = 3'd7;

    localparam logic [7:0] LEVEL_MAX    = 8'd255;
    localparam logic [7:0] LEVEL_MIN    = 8'd0;
    localparam logic [7:0] BREATHE_STEP = 8'd5;
    localparam logic [7:0] CHAN_STEP    = 8'd1;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TIME_W-1:0] now_ticks;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } out_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } color_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]  step_period;
        logic [PERIOD5_W-1:0] period_x5;
        logic                 load;
        color_t               base;
    } cfg_t;

endpackage

### rtl/lce_cfg.sv
// Configuration registers: step period, its five-fold value and the base colour
`timescale 1ns / 1ps
module lce_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [lce_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [lce_pkg::CFG_DATA_W-1:0]  wr_data,
    output lce_pkg::cfg_t                   cfg
);

    logic [lce_pkg::PERIOD_W-1:0]  step_period_reg, step_period_next;
    logic [lce_pkg::PERIOD5_W-1:0] period_x5_reg, period_x5_next;
    lce_pkg::color_t               base_reg, base_next;
    logic                          load;
    logic [lce_pkg::PERIOD5_W-1:0] data_ext;

    assign data_ext = {{(lce_pkg::PERIOD5_W - lce_pkg::PERIOD_W){1'b0}},
                       wr_data[lce_pkg::PERIOD_W-1:0]};

    always_comb
    begin
        step_period_next = step_period_reg;
        period_x5_next   = period_x5_reg;
        base_next        = base_reg;
        load             = 1'b0;
        if (wr_en)
        begin
            unique case (wr_index)
                lce_pkg::REG_STEP_PERIOD:
                begin
                    step_period_next = wr_data[lce_pkg::PERIOD_W-1:0];
                    period_x5_next   = (data_ext << 2) + data_ext;
                end
                lce_pkg::REG_BASE_RED:
                begin
                    base_next.r = wr_data[7:0];
                    load        = 1'b1;
                end
                lce_pkg::REG_BASE_GREEN:
                begin
                    base_next.g = wr_data[7:0];
                    load        = 1'b1;
                end
                lce_pkg::REG_BASE_BLUE:
                begin
                    base_next.b = wr_data[7:0];
                    load        = 1'b1;
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg <= lce_pkg::STEP_PERIOD_RESET;
            period_x5_reg   <= lce_pkg::PERIOD_X5_RESET;
            base_reg        <= '0;
        end
        else
        begin
            step_period_reg <= step_period_next;
            period_x5_reg   <= period_x5_next;
            base_reg        <= base_next;
        end
    end

    // a colour load carries the freshly written base straight through
    assign cfg.step_period = step_period_reg;
    assign cfg.period_x5   = period_x5_reg;
    assign cfg.load        = load;
    assign cfg.base        = base_next;

endmodule

### rtl/lce_engine.sv
// Effect state registers and the combinational step logic
`timescale 1ns / 1ps
module lce_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  lce_pkg::cfg_t     cfg,
    input  logic              fire,
    input  lce_pkg::in_item_t item,
    output lce_pkg::color_t   color
);

    lce_pkg::color_t              cur_reg, cur_next;
    lce_pkg::color_t              sav_reg, sav_next;
    logic [2:0]                   phase_reg, phase_next;
    logic [7:0]                   level_reg, level_next;
    logic                         dir_reg, dir_next;
    logic [lce_pkg::TIME_W-1:0]   last_reg, last_next;

    logic [lce_pkg::TIME_W:0]     now_ext;
    logic [lce_pkg::TIME_W:0]     deadline;
    logic [lce_pkg::TIME_W:0]     slow_deadline;
    logic                         due;
    logic                         slow_due;
    logic                         blink_due;
    logic                         record;

    // 33-bit sums so the deadline never wraps
    assign now_ext       = {1'b0, item.now_ticks};
    assign deadline      = {{(lce_pkg::TIME_W + 1 - lce_pkg::PERIOD_W){1'b0}}, cfg.step_period}
                           + {1'b0, last_reg};
    assign slow_deadline = {{(lce_pkg::TIME_W + 1 - lce_pkg::PERIOD5_W){1'b0}}, cfg.period_x5}
                           + {1'b0, last_reg};
    assign due           = now_ext >= deadline;
    assign slow_due      = now_ext >= slow_deadline;
    assign blink_due     = (item.kind == lce_pkg::KIND_SLOW_BLINK) ? slow_due : due;

    always_comb
    begin
        cur_next   = cur_reg;
        sav_next   = sav_reg;
        phase_next = phase_reg;
        level_next = level_reg;
        dir_next   = dir_reg;
        last_next  = last_reg;
        record     = 1'b1;
        if (cfg.load)
        begin
            cur_next = cfg.base;
            sav_next = cfg.base;
        end
        else if (fire && due)
        begin
            unique case (item.kind)
                lce_pkg::KIND_RAINBOW:
                begin
                    unique case (phase_reg)
                        lce_pkg::PHASE_RED_UP:
                        begin
                            cur_next.r = cur_reg.r + lce_pkg::CHAN_STEP;
                            if (cur_next.r == lce_pkg::LEVEL_MAX)
                                phase_next = lce_pkg::PHASE_GREEN_UP;
                        end
                        lce_pkg::PHASE_GREEN_UP:
                        begin
                            cur_next.g = cur_reg.g + lce_pkg::CHAN_STEP;
                            if (cur_next.g == lce_pkg::LEVEL_MAX)
                                phase_next = lce_pkg::PHASE_RED_DOWN;
                        end
                        lce_pkg::PHASE_RED_DOWN:
                        begin
                            cur_next.r = cur_reg.r - lce_pkg::CHAN_STEP;
                            if (cur_next.r == lce_pkg::LEVEL_MIN)
                                phase_next = lce_pkg::PHASE_BLUE_UP;
                        end
                        lce_pkg::PHASE_BLUE_UP:
                        begin
                            cur_next.b = cur_reg.b + lce_pkg::CHAN_STEP;
                            if (cur_next.b == lce_pkg::LEVEL_MAX)
                                phase_next = lce_pkg::PHASE_GREEN_DOWN;
                        end
                        lce_pkg::PHASE_GREEN_DOWN:
                        begin
                            cur_next.g = cur_reg.g - lce_pkg::CHAN_STEP;
                            if (cur_next.g == lce_pkg::LEVEL_MIN)
                                phase_next = lce_pkg::PHASE_RED_UP2;
                        end
                        lce_pkg::PHASE_RED_UP2:
                        begin
                            cur_next.r = cur_reg.r + lce_pkg::CHAN_STEP;
                            if (cur_next.r == lce_pkg::LEVEL_MAX)
                                phase_next = lce_pkg::PHASE_BLUE_DOWN;
                        end
                        lce_pkg::PHASE_BLUE_DOWN:
                        begin
                            cur_next.b = cur_reg.b - lce_pkg::CHAN_STEP;
                            if (cur_next.b == lce_pkg::LEVEL_MIN)
                                phase_next = lce_pkg::PHASE_GREEN_UP;
                        end
                        default:
                        begin
                            // unused phase: colour holds
                            phase_next = phase_reg;
                        end
                    endcase
                end
                lce_pkg::KIND_BREATHE:
                begin
                    if (dir_reg)
                    begin
                        if (level_reg == lce_pkg::LEVEL_MAX)
                            dir_next = 1'b0;
                        else
                            level_next = level_reg + lce_pkg::BREATHE_STEP;
                    end
                    else
                    begin
                        if (level_reg == lce_pkg::LEVEL_MIN)
                            dir_next = 1'b1;
                        else
                            level_next = level_reg - lce_pkg::BREATHE_STEP;
                    end
                    // dim the saved colour, floor at black
                    cur_next.r = (sav_reg.r < level_next) ? lce_pkg::LEVEL_MIN
                                                          : sav_reg.r - level_next;
                    cur_next.g = (sav_reg.g < level_next) ? lce_pkg::LEVEL_MIN
                                                          : sav_reg.g - level_next;
                    cur_next.b = (sav_reg.b < level_next) ? lce_pkg::LEVEL_MIN
                                                          : sav_reg.b - level_next;
                end
                lce_pkg::KIND_SLOW_BLINK, lce_pkg::KIND_BLINK:
                begin
                    if (blink_due)
                    begin
                        if (dir_reg)
                        begin
                            sav_next = cur_reg;
                            cur_next = '0;
                            dir_next = 1'b0;
                        end
                        else
                        begin
                            cur_next = sav_reg;
                            dir_next = 1'b1;
                        end
                    end
                    else
                    begin
                        record = 1'b0;
                    end
                end
                default:
                begin
                    record = 1'b1;
                end
            endcase
            if (record)
                last_next = item.now_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            sav_reg   <= '0;
            phase_reg <= lce_pkg::PHASE_RED_UP;
            level_reg <= '0;
            dir_reg   <= 1'b0;
            last_reg  <= '0;
        end
        else
        begin
            cur_reg   <= cur_next;
            sav_reg   <= sav_next;
            phase_reg <= phase_next;
            level_reg <= level_next;
            dir_reg   <= dir_next;
            last_reg  <= last_next;
        end
    end

    assign color = cur_next;

endmodule

### rtl/led_color_effect_generator_top.sv
// An accepted item is held in the input register and its result is captured in the
// result register when it advances. Throughput: one item per cycle unless the result
// side stalls; the combinational step logic between both registers updates the effect state.
// Reset (rst_n, asynchronous, active low) clears all effect state and the base
// colour, sets the step period to 100 and empties both registers.
`timescale 1ns / 1ps
`include "led_color_effect_generator_top_defines.svh"
module led_color_effect_generator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  lce_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output lce_pkg::out_item_t              out_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lce_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lce_pkg::cfg_t      cfg;
    lce_pkg::color_t    color;
    lce_pkg::in_item_t  in_item_reg;
    logic               in_valid_reg, in_valid_next;
    lce_pkg::out_item_t out_item_reg;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               advance;

    assign cfg_ready = 1'b1;

    lce_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lce_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .item  (in_item_reg),
        .color (color)
    );

    // advance the held item once the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_item;
        if (advance)
        begin
            out_item_reg.red_out   <= color.r;
            out_item_reg.green_out <= color.g;
            out_item_reg.blue_out  <= color.b;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `LCE_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, out_valid_reg)
    `LCE_ASSERT_NEXT(a_held_item_stays, clk, rst_n, in_valid_reg && !advance,
                     in_valid_reg && $stable(in_item_reg))
    `LCE_ASSERT_NEXT(a_taken_result_drains, clk, rst_n,
                     out_valid_reg && !out_stall && !advance, !out_valid_reg)
    `LCE_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, in_stall,
                        in_valid_reg && out_valid_reg && out_stall)

endmodule

### bench/tb_top.sv
// Self-checking bench for the LED colour effect generator: random timed items, config sweeps
`timescale 1ns / 1ps
module tb_top;
    import lce_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned STEADY_LO    = 350;
    localparam int unsigned STEADY_HI    = 500;
    localparam int unsigned HOLD_AT      = 650;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    // kinds that only record the time
    localparam logic [2:0] KIND_HOLD0 = 3'd0;
    localparam logic [2:0] KIND_HOLD5 = 3'd5;
    localparam logic [2:0] KIND_HOLD6 = 3'd6;
    localparam logic [2:0] KIND_HOLD7 = 3'd7;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predicted block state
    logic [PERIOD_W-1:0] cfg_period = STEP_PERIOD_RESET;
    color_t              cfg_base   = '0;
    color_t              cur_colour = '0;
    color_t              kept_colour = '0;
    logic [2:0]          fade_phase = PHASE_RED_UP;
    logic [7:0]          glow_level = LEVEL_MIN;
    logic                up_or_lit  = 1'b0;
    logic [TIME_W-1:0]   last_tick  = '0;

    in_item_t    pend_items[$];
    out_item_t   expected_colours[$];
    out_item_t   colour_due;
    int unsigned items_taken  = 0;
    int unsigned random_total = 0;
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic [TIME_W-1:0] tick_cursor = '0;

    led_color_effect_generator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] lvl);
        return (c < lvl) ? LEVEL_MIN : c - lvl;
    endfunction

    function automatic out_item_t next_colour(input in_item_t it);
        logic [32:0] due;
        logic [32:0] span;
        logic        stamp;
        out_item_t   res;
        stamp = 1'b1;
        due = {13'b0, cfg_period} + {1'b0, last_tick};
        if ({1'b0, it.now_ticks} >= due)
        begin
            case (it.kind)
                KIND_RAINBOW:
                begin
                    case (fade_phase)
                        PHASE_RED_UP:
                        begin
                            cur_colour.r = cur_colour.r + CHAN_STEP;
                            if (cur_colour.r == LEVEL_MAX) fade_phase = PHASE_GREEN_UP;
                        end
                        PHASE_GREEN_UP:
                        begin
                            cur_colour.g = cur_colour.g + CHAN_STEP;
                            if (cur_colour.g == LEVEL_MAX) fade_phase = PHASE_RED_DOWN;
                        end
                        PHASE_RED_DOWN:
                        begin
                            cur_colour.r = cur_colour.r - CHAN_STEP;
                            if (cur_colour.r == LEVEL_MIN) fade_phase = PHASE_BLUE_UP;
                        end
                        PHASE_BLUE_UP:
                        begin
                            cur_colour.b = cur_colour.b + CHAN_STEP;
                            if (cur_colour.b == LEVEL_MAX) fade_phase = PHASE_GREEN_DOWN;
                        end
                        PHASE_GREEN_DOWN:
                        begin
                            cur_colour.g = cur_colour.g - CHAN_STEP;
                            if (cur_colour.g == LEVEL_MIN) fade_phase = PHASE_RED_UP2;
                        end
                        PHASE_RED_UP2:
                        begin
                            cur_colour.r = cur_colour.r + CHAN_STEP;
                            if (cur_colour.r == LEVEL_MAX) fade_phase = PHASE_BLUE_DOWN;
                        end
                        PHASE_BLUE_DOWN:
                        begin
                            cur_colour.b = cur_colour.b - CHAN_STEP;
                            if (cur_colour.b == LEVEL_MIN) fade_phase = PHASE_GREEN_UP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                KIND_BREATHE:
                begin
                    if (up_or_lit)
                    begin
                        if (glow_level >= LEVEL_MAX) up_or_lit = 1'b0;
                        else glow_level = glow_level + BREATHE_STEP;
                    end
                    else
                    begin
                        if (glow_level == LEVEL_MIN) up_or_lit = 1'b1;
                        else glow_level = glow_level - BREATHE_STEP;
                    end
                    cur_colour.r = dim(kept_colour.r, glow_level);
                    cur_colour.g = dim(kept_colour.g, glow_level);
                    cur_colour.b = dim(kept_colour.b, glow_level);
                end
                KIND_SLOW_BLINK, KIND_BLINK:
                begin
                    span = (it.kind == KIND_SLOW_BLINK) ? {13'b0, cfg_period} * 33'd5
                                                        : {13'b0, cfg_period};
                    if ({1'b0, it.now_ticks} >= span + {1'b0, last_tick})
                    begin
                        if (up_or_lit)
                        begin
                            kept_colour = cur_colour;
                            cur_colour  = '0;
                            up_or_lit   = 1'b0;
                        end
                        else
                        begin
                            cur_colour = kept_colour;
                            up_or_lit  = 1'b1;
                        end
                    end
                    else
                    begin
                        // long interval not yet over: leave the time stamp alone
                        stamp = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (stamp) last_tick = it.now_ticks;
        end
        res.red_out   = cur_colour.r;
        res.green_out = cur_colour.g;
        res.blue_out  = cur_colour.b;
        return res;
    endfunction

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_STEP_PERIOD: cfg_period = data;
            REG_BASE_RED:    cfg_base.r = data[7:0];
            REG_BASE_GREEN:  cfg_base.g = data[7:0];
            default:         cfg_base.b = data[7:0];
        endcase
        if (idx != REG_STEP_PERIOD)
        begin
            cur_colour  = cfg_base;
            kept_colour = cfg_base;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic take_gap();
        if (items_taken >= STEADY_LO && items_taken < STEADY_HI) return 1'b0;
        return $urandom_range(0, 99) < 30;
    endfunction

    task automatic queue_item(input logic [2:0] kind, input logic [TIME_W-1:0] now);
        in_item_t it;
        it.kind      = kind;
        it.now_ticks = now;
        pend_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pend_items.size() != 0 || in_valid || expected_colours.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_chan(input string chan, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, chan, want, got);
            fail_count++;
        end
    endtask

    // favour levels near the ends so fades reach their targets quickly
    function automatic logic [7:0] chan_level();
        int unsigned pick;
        pick = $urandom_range(0, 2);
        if (pick == 0) return 8'($urandom_range(0, 6));
        if (pick == 1) return 8'($urandom_range(249, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic reshape_config();
        logic [CFG_DATA_W-1:0] junk;
        int unsigned pick;
        junk = CFG_DATA_W'($urandom());
        if ($urandom_range(0, 1) == 1)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0) write_reg(REG_STEP_PERIOD, '0);
            else if (pick == 1) write_reg(REG_STEP_PERIOD, CFG_DATA_W'(1));
            else if (pick < 12) write_reg(REG_STEP_PERIOD, CFG_DATA_W'($urandom_range(2, 12)));
            else if (pick < 18) write_reg(REG_STEP_PERIOD, CFG_DATA_W'($urandom_range(13, 400)));
            else if (pick == 18) write_reg(REG_STEP_PERIOD, junk);
            else write_reg(REG_STEP_PERIOD, '1);
        end
        if ($urandom_range(0, 1) == 1) write_reg(REG_BASE_RED, {junk[19:8], chan_level()});
        if ($urandom_range(0, 1) == 1) write_reg(REG_BASE_GREEN, {junk[19:8], chan_level()});
        if ($urandom_range(0, 1) == 1) write_reg(REG_BASE_BLUE, {junk[19:8], chan_level()});
    endtask

    // the tick cursor only moves forward, since the last step time can never fall back; some items reuse earlier times
    task automatic queue_burst();
        int unsigned       n;
        int unsigned       pick;
        logic              mixed;
        logic [2:0]        lead;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] delta;
        in_item_t          it;
        step  = {12'b0, cfg_period};
        n     = (cfg_period > 4096) ? $urandom_range(8, 15) : $urandom_range(20, 60);
        mixed = ($urandom_range(0, 4) == 0);
        lead  = 3'($urandom_range(KIND_RAINBOW, KIND_BLINK));
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                it.kind      = 3'($urandom_range(0, 7));
                it.now_ticks = ($urandom_range(0, 2) == 0) ? $urandom_range(0, tick_cursor)
                                                           : tick_cursor;
            end
            else
            begin
                it.kind = mixed ? 3'($urandom_range(KIND_RAINBOW, KIND_BLINK)) : lead;
                pick = $urandom_range(0, 99);
                if (pick < 30) delta = step;
                else if (pick < 45) delta = step - 1;
                else if (pick < 80) delta = $urandom_range(0, 2 * step + 2);
                else if (pick < 90) delta = 5 * step;
                else delta = 5 * step - 1;
                tick_cursor  = tick_cursor + delta;
                it.now_ticks = tick_cursor;
            end
            pend_items.push_back(it);
        end
        random_total += n;
    endtask

    // driver: offer pending items, hold the payload while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_colours.push_back(next_colour(in_item));
                items_taken <= items_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pend_items.size() != 0 && !take_gap())
                begin
                    in_item  <= pend_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // one long hold-off on the result side so the block backs up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_taken >= HOLD_AT && pend_items.size() >= 8)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // monitor: compare each colour item with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_colours.size() == 0)
                begin
                    $display("%0t: colour item with none expected, expected none, got %h",
                             $time, out_item);
                    fail_count++;
                end
                else
                begin
                    colour_due = expected_colours.pop_front();
                    check_chan("red_out", colour_due.red_out, out_item.red_out);
                    check_chan("green_out", colour_due.green_out, out_item.green_out);
                    check_chan("blue_out", colour_due.blue_out, out_item.blue_out);
                end
            end
            out_stall <= (hold_left != 0) || take_gap();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: not reached, first steps, blink intervals, breathe start, hold kinds
        queue_item(KIND_HOLD0, 32'd0);
        queue_item(KIND_RAINBOW, 32'd99);
        queue_item(KIND_RAINBOW, 32'd100);
        queue_item(KIND_BLINK, 32'd200);
        queue_item(KIND_SLOW_BLINK, 32'd300);
        queue_item(KIND_SLOW_BLINK, 32'd699);
        queue_item(KIND_SLOW_BLINK, 32'd700);
        queue_item(KIND_BREATHE, 32'd800);
        queue_item(KIND_BREATHE, 32'd900);
        queue_item(KIND_HOLD5, 32'd1000);
        queue_item(KIND_HOLD6, 32'd1050);
        queue_item(KIND_HOLD7, 32'd1100);
        wait_idle();

        // zero period, channel wrap on the fade, floor on the breathe
        write_reg(REG_STEP_PERIOD, '0);
        write_reg(REG_BASE_RED, '1);
        write_reg(REG_BASE_GREEN, 20'hABC00);
        write_reg(REG_BASE_BLUE, 20'h00F05);
        queue_item(KIND_RAINBOW, 32'd1100);
        queue_item(KIND_RAINBOW, 32'd1100);
        queue_item(KIND_BREATHE, 32'd1100);
        queue_item(KIND_BLINK, 32'd1100);
        queue_item(KIND_SLOW_BLINK, 32'd1100);
        queue_item(KIND_HOLD0, 32'd1099);
        wait_idle();

        tick_cursor = 32'd1100;
        while (random_total < RANDOM_ITEMS)
        begin
            reshape_config();
            queue_burst();
            wait_idle();
        end

        // top of the time range last, as it pins the step time there for good
        write_reg(REG_STEP_PERIOD, STEP_PERIOD_RESET);
        queue_item(KIND_HOLD7, '1);
        queue_item(KIND_RAINBOW, '1);
        wait_idle();
        write_reg(REG_STEP_PERIOD, '0);
        queue_item(KIND_RAINBOW, '1);
        queue_item(KIND_BLINK, '0);
        wait_idle();
        write_reg(REG_STEP_PERIOD, '1);
        queue_item(KIND_SLOW_BLINK, '1);
        wait_idle();

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
